>>> sv/apr_pkg.sv
// Aging page replacement: shared constants and the frame table entry type.
// No dependencies; imported by apr_frame_store and aging_page_replacement_top.
package apr_pkg;

	localparam int NUM_FRAMES = 8;
	localparam int FRAME_W    = 3;
	localparam int CNT_W      = FRAME_W + 1;
	localparam int PAGE_BITS  = 8;
	localparam int HIST_W     = 8;
	localparam int PERIOD_W   = 16;
	localparam int FAULT_W    = 32;

	localparam logic [HIST_W-1:0]   HIST_FULL    = 8'hFF;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
	localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd1;

	typedef struct packed {
		logic [PAGE_BITS-1:0] page;
		logic                 holds;
		logic                 refd;
		logic [HIST_W-1:0]    hist;
	} frame_entry_t;

endpackage

>>> sv/apr_frame_store.sv
// Frame table memory: one entry per page frame, one write and one registered read port.
// Per-entry valid flops make unwritten entries read as an empty frame. Uses apr_pkg.
module apr_frame_store (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [apr_pkg::FRAME_W-1:0]        wr_addr,
	input  apr_pkg::frame_entry_t              wr_data,
	input  logic                               rd_en,
	input  logic [apr_pkg::FRAME_W-1:0]        rd_addr,
	output apr_pkg::frame_entry_t              rd_data
);
	import apr_pkg::*;

	frame_entry_t           mem_q [NUM_FRAMES];
	logic [NUM_FRAMES-1:0]  vld_q;
	frame_entry_t           rd_raw_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

>>> sv/aging_page_replacement_top.sv
// Aging page replacement over eight page frames, 8-bit history per frame.
// Depends on apr_pkg and apr_frame_store (frame table memory).
//
// Usage:
//   A reference is accepted at a clock edge with start high and busy low.
//   The block then sweeps the frame table, one frame read per cycle from a
//   memory with a registered read port, aging each frame on the way when
//   the reference count calls for it, looking for a hit and tracking the
//   frame with the lowest history. A commit state then writes the hit or the new
//   page back. The result shows on hit, frame_index, evicted_page,
//   evicted_valid and fault_total for one cycle with done high; busy falls
//   in that same cycle, so the next reference is accepted at the edge
//   ending it. Busy stays high through the sweep and the commit, so no new
//   reference is taken before the last result shows. The result receiver cannot
//   stall; a result transfer is complete at the edge ending the done cycle.
//   The user must write aging_period through aging_period_we/aging_period_wdata
//   only while busy is low; the block itself does not enforce it. Reset empties all
//   frames, clears histories, counts and the fault counter, and sets aging_period to 100.
module aging_page_replacement_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [apr_pkg::PAGE_BITS-1:0]     requested_page,
	input  logic                              aging_period_we,
	input  logic [apr_pkg::PERIOD_W-1:0]      aging_period_wdata,
	output logic                              done,
	output logic                              hit,
	output logic [apr_pkg::FRAME_W-1:0]       frame_index,
	output logic [apr_pkg::PAGE_BITS-1:0]     evicted_page,
	output logic                              evicted_valid,
	output logic [apr_pkg::FAULT_W-1:0]       fault_total
);
	import apr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t                 state_q;
	logic [PERIOD_W-1:0]    period_q;
	logic [PERIOD_W-1:0]    ref_cnt_q;
	logic [PERIOD_W-1:0]    cnt_eff_q;
	logic                   age_q;
	logic [PAGE_BITS-1:0]   page_q;
	logic [CNT_W-1:0]       rd_cnt_q;
	logic                   valid_s1;
	logic [FRAME_W-1:0]     idx_s1;
	logic                   hit_found_q;
	logic [FRAME_W-1:0]     hit_idx_q;
	frame_entry_t           hit_entry_q;
	logic [HIST_W-1:0]      best_q;
	logic [FRAME_W-1:0]     victim_idx_q;
	frame_entry_t           victim_entry_q;
	logic [FAULT_W-1:0]     fault_q;
	logic                   done_q;
	logic                   hit_q;
	logic [FRAME_W-1:0]     frame_q;
	logic [PAGE_BITS-1:0]   ev_page_q;
	logic                   ev_valid_q;

	logic                   accept;
	logic [PERIOD_W-1:0]    period_eff;
	logic [PERIOD_W-1:0]    cnt_eff;
	logic [PERIOD_W:0]      cnt_inc;
	logic                   rd_en;
	frame_entry_t           rd_data;
	frame_entry_t           cur;
	logic                   cur_hit;
	logic                   last_s1;
	logic                   wr_en;
	logic [FRAME_W-1:0]     wr_addr;
	frame_entry_t           wr_data;

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign period_eff = (period_q == '0) ? PERIOD_MIN : period_q;
	assign cnt_eff    = (ref_cnt_q >= period_eff) ? '0 : ref_cnt_q;
	assign cnt_inc    = {1'b0, cnt_eff_q} + {{PERIOD_W{1'b0}}, 1'b1};
	assign rd_en      = (state_q == ST_SCAN) && (rd_cnt_q < CNT_W'(NUM_FRAMES));
	assign last_s1    = valid_s1 && (idx_s1 == FRAME_W'(NUM_FRAMES - 1));

	// aging applied to each entry as it streams out of the table
	always_comb begin
		cur = rd_data;
		if (age_q) begin
			cur.hist = {rd_data.refd, rd_data.hist[HIST_W-1:1]};
			cur.refd = 1'b0;
		end
		cur_hit = cur.holds && (cur.page == page_q) && !hit_found_q;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = cur;
		if (valid_s1 && age_q) begin
			wr_en = 1'b1;
		end else if (state_q == ST_COMMIT) begin
			wr_en = 1'b1;
			if (hit_found_q) begin
				wr_addr      = hit_idx_q;
				wr_data      = hit_entry_q;
				wr_data.refd = 1'b1;
			end else begin
				wr_addr       = victim_idx_q;
				wr_data       = victim_entry_q;
				wr_data.page  = page_q;
				wr_data.holds = 1'b1;
				wr_data.refd  = 1'b1;
			end
		end
	end

	apr_frame_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_cnt_q[FRAME_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			period_q  <= PERIOD_RESET;
			ref_cnt_q <= '0;
			fault_q   <= '0;
			rd_cnt_q  <= '0;
			valid_s1  <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			valid_s1 <= rd_en;
			if (aging_period_we) begin
				period_q <= aging_period_wdata;
			end
			if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_cnt_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_s1) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					done_q    <= 1'b1;
					ref_cnt_q <= (cnt_inc >= {1'b0, period_eff}) ? '0 : cnt_inc[PERIOD_W-1:0];
					if (!hit_found_q && (fault_q != '1)) begin
						fault_q <= fault_q + FAULT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[FRAME_W-1:0];
		if (accept) begin
			page_q      <= requested_page;
			cnt_eff_q   <= cnt_eff;
			age_q       <= (cnt_eff == '0);
			hit_found_q <= 1'b0;
			best_q      <= HIST_FULL;
		end
		if (valid_s1) begin
			if (cur_hit) begin
				hit_found_q <= 1'b1;
				hit_idx_q   <= idx_s1;
				hit_entry_q <= cur;
			end
			if ((cur.hist < best_q) || (idx_s1 == '0)) begin
				best_q         <= cur.hist;
				victim_idx_q   <= idx_s1;
				victim_entry_q <= cur;
			end
		end
		if (state_q == ST_COMMIT) begin
			hit_q      <= hit_found_q;
			frame_q    <= hit_found_q ? hit_idx_q : victim_idx_q;
			ev_valid_q <= !hit_found_q && victim_entry_q.holds;
			ev_page_q  <= (!hit_found_q && victim_entry_q.holds) ? victim_entry_q.page : '0;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign frame_index   = frame_q;
	assign evicted_page  = ev_page_q;
	assign evicted_valid = ev_valid_q;
	assign fault_total   = fault_q;

	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_COMMIT))
		else $error("result strobe without a commit cycle");

	a_no_read_data_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_COMMIT) |-> !valid_s1)
		else $error("frame read data outside the sweep");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && evicted_valid))
		else $error("hit result reports an eviction");

	a_fault_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> $stable(fault_total))
		else $error("fault counter moved on a hit");

endmodule
